/* src/mva_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mva_pkg;
  localparam int COORD_BITS = 16;
  localparam int MAX_TRIANGLES_LOG2 = 12;
  localparam int CNT_W = MAX_TRIANGLES_LOG2 + 1;
  localparam int VOL_W = 61;
  localparam int AREA_W = 47;
  localparam int OUT_VOL_W = 59;
  localparam int OUT_AREA_W = 46;
  localparam int SQ_W = 72;
  localparam int ROOT_W = 36;
  localparam int PROD_W = 66;

  typedef struct packed {
    logic signed [15:0] vertex_a_x;
    logic signed [15:0] vertex_a_y;
    logic signed [15:0] vertex_a_z;
    logic signed [15:0] vertex_b_x;
    logic signed [15:0] vertex_b_y;
    logic signed [15:0] vertex_b_z;
    logic signed [15:0] vertex_c_x;
    logic signed [15:0] vertex_c_y;
    logic signed [15:0] vertex_c_z;
    logic last_triangle;
  } tri_t;

  typedef struct packed {
    logic signed [58:0] mesh_volume;
    logic [45:0] twice_area;
    logic overflow;
  } res_t;

  // multiplier operand selects
  typedef enum logic [3:0] {
    OP_BZCY, OP_BYCZ, OP_BXCZ, OP_BZCX, OP_BYCX, OP_BXCY,
    OP_UYVZ, OP_UZVY, OP_UZVX, OP_UXVZ, OP_UXVY, OP_UYVX,
    OP_NXNX, OP_NYNY, OP_NZNZ, OP_TRIPLE
  } mop_t;

  typedef struct packed {
    logic load;
    logic mul_go;
    mop_t mop;
    logic sqrt_start;
    logic sqrt_step;
    logic accumulate;
    logic div_load;
    logic div_step;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic last;
  } sts_t;
endpackage
`default_nettype wire

/* src/mva_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface mva_tri_if;
  logic valid;
  logic ready;
  mva_pkg::tri_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface mva_res_if;
  logic valid;
  logic ready;
  mva_pkg::res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/mva_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module mva_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire mva_pkg::sts_t sts,
  output mva_pkg::cmd_t cmd
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_MUL = 7'b0000010, S_SQRT = 7'b0000100,
    S_ACC = 7'b0001000, S_DIV = 7'b0010000, S_OUT = 7'b0100000,
    S_SQI = 7'b1000000
  } state_t;
  state_t state_r, state_nxt;
  logic [3:0] op_r, op_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cmd = '0;
    cmd.mop = mva_pkg::mop_t'(op_r);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_MUL;
          op_nxt = '0;
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        op_nxt = op_r + 4'd1;
        if (op_r == 4'(mva_pkg::OP_TRIPLE)) state_nxt = S_SQI;
      end
      S_SQI: begin
        cmd.sqrt_start = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.accumulate = 1'b1;
        if (sts.last) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (!sts.div_done) cmd.div_step = 1'b1;
        else state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.div_load = (state_r == S_ACC) && sts.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r <= '0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
    end
  end
endmodule
`default_nettype wire

/* src/mva_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module mva_dp (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire mva_pkg::tri_t in_tri,
  input  wire mva_pkg::cmd_t cmd,
  output mva_pkg::sts_t sts,
  output mva_pkg::res_t res
);
  localparam int CB = mva_pkg::COORD_BITS;
  localparam int PW = mva_pkg::PROD_W;
  localparam int CW = 2 * CB + 2;  // cross product width
  localparam logic [mva_pkg::CNT_W-1:0] LIMIT =
    mva_pkg::CNT_W'(1) << mva_pkg::MAX_TRIANGLES_LOG2;
  localparam logic signed [mva_pkg::VOL_W-1:0] VMAX = {1'b0, {(mva_pkg::VOL_W-1){1'b1}}};
  localparam logic signed [mva_pkg::VOL_W-1:0] VMIN = {1'b1, {(mva_pkg::VOL_W-1){1'b0}}};
  localparam logic [mva_pkg::AREA_W-1:0] AMAX = {1'b0, {(mva_pkg::AREA_W-1){1'b1}}};

  logic signed [CB:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r, cx_r, cy_r, cz_r;
  logic signed [CB:0] ux, uy, uz, vx, vy, vz;
  logic last_r;
  logic signed [CW-1:0] t0_r, t1_r, t2_r, nx_r, ny_r, nz_r, p_hold_r;
  logic signed [PW-1:0] triple_r;
  logic [mva_pkg::SQ_W-1:0] sq_r;
  logic signed [CW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [CW-1:0] a_ext, prev_cross;
  logic [1:0] tstep_r;
  logic signed [CW-1:0] tsel;

  function automatic logic signed [CB:0] sx(input logic [15:0] v);
    return (CB+1)'(signed'(v[CB-1:0]));
  endfunction

  assign ux = bx_r - ax_r; assign uy = by_r - ay_r; assign uz = bz_r - az_r;
  assign vx = cx_r - ax_r; assign vy = cy_r - ay_r; assign vz = cz_r - az_r;

  // multiplier shared by the cross-product and square steps; operands picked per step
  always_comb begin
    ma = '0; mb = '0;
    case (cmd.mop)
      mva_pkg::OP_BZCY: begin ma = CW'(bz_r); mb = CW'(cy_r); end
      mva_pkg::OP_BYCZ: begin ma = CW'(by_r); mb = CW'(cz_r); end
      mva_pkg::OP_BXCZ: begin ma = CW'(bx_r); mb = CW'(cz_r); end
      mva_pkg::OP_BZCX: begin ma = CW'(bz_r); mb = CW'(cx_r); end
      mva_pkg::OP_BYCX: begin ma = CW'(by_r); mb = CW'(cx_r); end
      mva_pkg::OP_BXCY: begin ma = CW'(bx_r); mb = CW'(cy_r); end
      mva_pkg::OP_UYVZ: begin ma = CW'(uy); mb = CW'(vz); end
      mva_pkg::OP_UZVY: begin ma = CW'(uz); mb = CW'(vy); end
      mva_pkg::OP_UXVZ: begin ma = CW'(ux); mb = CW'(vz); end
      mva_pkg::OP_UZVX: begin ma = CW'(uz); mb = CW'(vx); end
      mva_pkg::OP_UXVY: begin ma = CW'(ux); mb = CW'(vy); end
      mva_pkg::OP_UYVX: begin ma = CW'(uy); mb = CW'(vx); end
      mva_pkg::OP_NXNX: begin ma = nx_r; mb = nx_r; end
      mva_pkg::OP_NYNY: begin ma = ny_r; mb = ny_r; end
      mva_pkg::OP_NZNZ: begin ma = nz_r; mb = nz_r; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign prod = PW'(ma) * PW'(mb);
  assign prev_cross = p_hold_r - CW'(prod);

  // load, multiplier steps and triple term: a-component times cross term, done as dot products with a
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= sx(in_tri.vertex_a_x); ay_r <= sx(in_tri.vertex_a_y);
      az_r <= sx(in_tri.vertex_a_z); bx_r <= sx(in_tri.vertex_b_x);
      by_r <= sx(in_tri.vertex_b_y); bz_r <= sx(in_tri.vertex_b_z);
      cx_r <= sx(in_tri.vertex_c_x); cy_r <= sx(in_tri.vertex_c_y);
      cz_r <= sx(in_tri.vertex_c_z);
      last_r <= in_tri.last_triangle;
      triple_r <= '0;
      sq_r <= '0;
    end else if (cmd.mul_go) begin
      case (cmd.mop)
        mva_pkg::OP_BZCY, mva_pkg::OP_BXCZ, mva_pkg::OP_BYCX,
        mva_pkg::OP_UYVZ, mva_pkg::OP_UZVX, mva_pkg::OP_UXVY:
          p_hold_r <= CW'(prod);
        mva_pkg::OP_BYCZ: t0_r <= CW'(prod) - p_hold_r;
        mva_pkg::OP_BZCX: t1_r <= CW'(prod) - p_hold_r;
        mva_pkg::OP_BXCY: t2_r <= CW'(prod) - p_hold_r;
        mva_pkg::OP_UZVY: nx_r <= prev_cross;
        mva_pkg::OP_UXVZ: ny_r <= prev_cross;
        mva_pkg::OP_UYVX: nz_r <= prev_cross;
        mva_pkg::OP_NXNX, mva_pkg::OP_NYNY, mva_pkg::OP_NZNZ:
          sq_r <= sq_r + mva_pkg::SQ_W'(unsigned'(prod));
        default: ;
      endcase
    end else if (tstep_r != 2'd3) begin
      triple_r <= triple_r + PW'(a_ext) * PW'(tsel);
    end
  end

  // three a-times-term products after the main sequence
  always_comb begin
    case (tstep_r)
      2'd0: begin a_ext = CW'(ax_r); tsel = t0_r; end
      2'd1: begin a_ext = CW'(ay_r); tsel = t1_r; end
      2'd2: begin a_ext = CW'(az_r); tsel = t2_r; end
      default: begin a_ext = '0; tsel = '0; end
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) tstep_r <= 2'd3;
    else if (cmd.sqrt_start) tstep_r <= 2'd0;
    else if (tstep_r != 2'd3) tstep_r <= tstep_r + 2'd1;
  end

  // restoring square root, one bit a cycle
  logic [mva_pkg::SQ_W-1:0] rem_r;
  logic [mva_pkg::ROOT_W-1:0] root_r;
  logic [5:0] sqc_r;
  logic [mva_pkg::SQ_W-1:0] rem_sh;
  logic [mva_pkg::ROOT_W+1:0] trial;
  logic [mva_pkg::SQ_W-1:0] rad_r;
  assign rem_sh = {rem_r[mva_pkg::SQ_W-3:0], rad_r[mva_pkg::SQ_W-1 -: 2]};
  assign trial = {root_r, 2'b01};
  always_ff @(posedge clk) begin
    if (!rst_n) sqc_r <= '0;
    else if (cmd.sqrt_start) begin
      rad_r <= sq_r; rem_r <= '0; root_r <= '0;
      sqc_r <= 6'(mva_pkg::ROOT_W);
    end else if (cmd.sqrt_step && sqc_r != '0) begin
      rad_r <= rad_r << 2;
      if (rem_sh >= mva_pkg::SQ_W'(trial)) begin
        rem_r <= rem_sh - mva_pkg::SQ_W'(trial);
        root_r <= {root_r[mva_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        root_r <= {root_r[mva_pkg::ROOT_W-2:0], 1'b0};
      end
      sqc_r <= sqc_r - 6'd1;
    end
  end
  assign sts.sqrt_done = (sqc_r == '0) && (tstep_r == 2'd3);
  assign sts.last = last_r;

  // accumulators
  logic signed [mva_pkg::VOL_W-1:0] vol_r;
  logic [mva_pkg::AREA_W-1:0] area_r;
  logic [mva_pkg::CNT_W-1:0] cnt_r;
  logic ovf_r;
  logic signed [mva_pkg::VOL_W+1:0] vsum;
  logic [mva_pkg::AREA_W:0] asum;
  assign vsum = (mva_pkg::VOL_W+2)'(vol_r) + (mva_pkg::VOL_W+2)'(triple_r);
  assign asum = (mva_pkg::AREA_W+1)'(area_r) + (mva_pkg::AREA_W+1)'(root_r);
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vol_r <= '0; area_r <= '0; cnt_r <= '0; ovf_r <= 1'b0;
    end else if (cmd.accumulate) begin
      if (cnt_r >= LIMIT) ovf_r <= 1'b1;
      else cnt_r <= cnt_r + mva_pkg::CNT_W'(1);
      if (vsum > (mva_pkg::VOL_W+2)'(VMAX)) vol_r <= VMAX;
      else if (vsum < (mva_pkg::VOL_W+2)'(VMIN)) vol_r <= VMIN;
      else vol_r <= vsum[mva_pkg::VOL_W-1:0];
      area_r <= (asum > (mva_pkg::AREA_W+1)'(AMAX)) ? AMAX : asum[mva_pkg::AREA_W-1:0];
    end
  end

  // divide magnitude by six, 16 bits a cycle, digit from a reciprocal multiply
  localparam int VW = mva_pkg::VOL_W;
  localparam int DIG = 16;
  localparam int DW = 64;           // magnitude padded to whole digits
  localparam int DV_W = DIG + 3;    // remainder below six ahead of one digit
  localparam logic [19:0] RECIP6 = 20'd699051;  // ceil(2^22 / 6), exact below 2^21
  logic [DW-1:0] dn_r, q_r;
  logic [2:0] dr_r;
  logic [2:0] dc_r;
  logic neg_r;
  logic [DV_W-1:0] dv;
  logic [DIG-1:0] dq;
  logic [2:0] drem;
  logic signed [VW-1:0] vol_fin;
  logic [VW-1:0] vmag;
  assign vol_fin = (vsum > (mva_pkg::VOL_W+2)'(VMAX)) ? VMAX :
                   (vsum < (mva_pkg::VOL_W+2)'(VMIN)) ? VMIN : vsum[VW-1:0];
  assign vmag = vol_fin[VW-1] ? VW'(-vol_fin) : VW'(vol_fin);
  assign dv = {dr_r, dn_r[DW-1 -: DIG]};
  assign dq = DIG'((40'(dv) * 40'(RECIP6)) >> 22);
  assign drem = 3'(dv - DV_W'(dq) * DV_W'(6));
  always_ff @(posedge clk) begin
    if (!rst_n) dc_r <= '0;
    else if (cmd.div_load) begin
      neg_r <= vol_fin[VW-1];
      dn_r <= DW'(vmag);
      dr_r <= '0; q_r <= '0; dc_r <= 3'(DW / DIG);
    end else if (cmd.div_step) begin
      dn_r <= dn_r << DIG;
      q_r <= {q_r[DW-DIG-1:0], dq};
      dr_r <= drem;
      dc_r <= dc_r - 3'd1;
    end
  end
  assign sts.div_done = (dc_r == '0);
  assign res.mesh_volume = mva_pkg::OUT_VOL_W'(neg_r ? -q_r : q_r);
  assign res.twice_area = area_r[mva_pkg::OUT_AREA_W-1:0];
  assign res.overflow = ovf_r;
endmodule
`default_nettype wire

/* src/mesh_volume_and_area.sv */
`timescale 1ns / 1ps
`default_nettype none
// Mesh volume and surface area: one triangle per input beat. Each accepted beat passes
// through a load, the slots of the shared multiplier, a square-root setup, the square-root
// steps and their finish, and an accumulate before the next beat can be taken; a triangle
// with last_triangle set adds a divide by six (four 16-bit digits and a finish) before its
// result beat is offered, and the block takes no triangle until that result
// has been taken.
module mesh_volume_and_area (
  input wire logic clk,
  input wire logic rst_n,
  mva_tri_if.sink in_tri,
  mva_res_if.source out_res
);
  mva_pkg::cmd_t cmd;
  mva_pkg::sts_t sts;
  mva_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_tri.valid), .in_ready(in_tri.ready),
    .out_valid(out_res.valid), .out_ready(out_res.ready), .sts, .cmd
  );
  mva_dp u_dp (
    .clk, .rst_n, .in_tri(in_tri.data), .cmd, .sts, .res(out_res.data)
  );
endmodule
`default_nettype wire

/* src/mva_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module mva_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire mva_pkg::res_t out_data
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken during result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after beat");
  a_ovf_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow == 1'b0 |-> out_data.twice_area != '1)
    else $error("area saturated without overflow");
endmodule

bind mesh_volume_and_area mva_checker u_chk (
  .clk, .rst_n, .in_valid(in_tri.valid), .in_ready(in_tri.ready),
  .out_valid(out_res.valid), .out_ready(out_res.ready), .out_data(out_res.data)
);
`default_nettype wire

/* dv/mesh_volume_and_area_test.sv */
`timescale 1ns / 1ps
module mesh_volume_and_area_test;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_BEATS = 2000;
  localparam int CALM_BEATS = 300;
  localparam int LONG_HOLD = 300;
  localparam longint VOL_HI = (64'sd1 <<< 60) - 1;
  localparam longint VOL_LO = -(64'sd1 <<< 60);
  localparam logic [46:0] AREA_HI = (47'd1 << 46) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mva_tri_if tri_ch();
  mva_res_if res_ch();

  mesh_volume_and_area uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tri(tri_ch.sink),
    .out_res(res_ch.source)
  );

  always #6 clk = ~clk;

  // predictor state
  longint vol_acc;
  logic [46:0] area_acc;
  int facet_cnt;
  bit ovf_seen;

  mva_pkg::res_t mesh_results[$];
  int mismatches = 0;
  int results_taken = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  typedef struct {
    mva_pkg::tri_t facet;
    int beats;
    bit typed;
    mva_pkg::res_t want;
  } row_t;

  function automatic longint grid(logic signed [15:0] f);
    longint x;
    x = longint'(f);
    x = (x <<< (64 - mva_pkg::COORD_BITS)) >>> (64 - mva_pkg::COORD_BITS);
    return x;
  endfunction

  function automatic logic [71:0] mag_sq(longint v);
    logic [71:0] m;
    m = (v < 0) ? 72'(-v) : 72'(v);
    return m * m;
  endfunction

  // accumulates one facet, returns 1 with the mesh totals on the last one
  function automatic bit accumulate_facet(mva_pkg::tri_t t, output mva_pkg::res_t r);
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz, triple;
    logic [71:0] len_sq, probe;
    logic [35:0] root;
    ax = grid(t.vertex_a_x); ay = grid(t.vertex_a_y); az = grid(t.vertex_a_z);
    bx = grid(t.vertex_b_x); by = grid(t.vertex_b_y); bz = grid(t.vertex_b_z);
    cx = grid(t.vertex_c_x); cy = grid(t.vertex_c_y); cz = grid(t.vertex_c_z);
    triple = ax * (by * cz - bz * cy) + ay * (bz * cx - bx * cz)
           + az * (bx * cy - by * cx);
    ux = bx - ax; uy = by - ay; uz = bz - az;
    vx = cx - ax; vy = cy - ay; vz = cz - az;
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    len_sq = mag_sq(nx) + mag_sq(ny) + mag_sq(nz);
    root = '0;
    for (int b = 35; b >= 0; b--) begin
      probe = 72'(root | (36'd1 << b));
      if (probe * probe <= len_sq) root = root | (36'd1 << b);
    end
    if (facet_cnt >= (1 << mva_pkg::MAX_TRIANGLES_LOG2)) ovf_seen = 1'b1;
    else facet_cnt++;
    vol_acc = vol_acc + triple;
    if (vol_acc > VOL_HI) vol_acc = VOL_HI;
    if (vol_acc < VOL_LO) vol_acc = VOL_LO;
    area_acc = area_acc + 47'(root);
    if (area_acc > AREA_HI) area_acc = AREA_HI;
    r = '0;
    if (!t.last_triangle) return 1'b0;
    r.mesh_volume = 59'(vol_acc / 6);
    r.twice_area = area_acc[45:0];
    r.overflow = ovf_seen;
    vol_acc = 0; area_acc = '0; facet_cnt = 0; ovf_seen = 1'b0;
    return 1'b1;
  endfunction

  function automatic mva_pkg::tri_t make_facet(longint a0, longint a1, longint a2,
      longint b0, longint b1, longint b2, longint c0, longint c1, longint c2, bit last);
    mva_pkg::tri_t t;
    t.vertex_a_x = 16'(a0); t.vertex_a_y = 16'(a1); t.vertex_a_z = 16'(a2);
    t.vertex_b_x = 16'(b0); t.vertex_b_y = 16'(b1); t.vertex_b_z = 16'(b2);
    t.vertex_c_x = 16'(c0); t.vertex_c_y = 16'(c1); t.vertex_c_z = 16'(c2);
    t.last_triangle = last;
    return t;
  endfunction

  function automatic logic [15:0] random_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 128) - 64);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return 16'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  // offers one beat, waits until it is taken, and with allow_gap may then drop valid for a random gap
  task automatic send_facet(mva_pkg::tri_t t, bit typed, mva_pkg::res_t want,
      bit allow_gap);
    mva_pkg::res_t r;
    tri_ch.data <= t;
    tri_ch.valid <= 1'b1;
    do @(posedge clk); while (!tri_ch.ready);
    if (accumulate_facet(t, r)) mesh_results.insert(mesh_results.size(), typed ? want : r);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      tri_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if ((tri_ch.valid && tri_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: checks beats and throttles ready
  initial begin
    int stall_left;
    bit held;
    bit waiting;
    mva_pkg::res_t want;
    stall_left = 0;
    held = 1'b0;
    waiting = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        results_taken++;
        if (mesh_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", res_ch.data);
        end else begin
          want = mesh_results.pop_front();
          if (res_ch.data.mesh_volume !== want.mesh_volume
              || res_ch.data.twice_area !== want.twice_area
              || res_ch.data.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected vol %0d area %0d ovf %0b, got vol %0d area %0d ovf %0b",
                       results_taken, want.mesh_volume, want.twice_area, want.overflow,
                       res_ch.data.mesh_volume, res_ch.data.twice_area, res_ch.data.overflow);
          end
        end
      end
      if (!held && results_taken == 40) begin
        // hold off until a result is waiting, then keep it waiting so the input backs up
        held = 1'b1;
        waiting = 1'b1;
      end
      if (waiting && res_ch.valid && !res_ch.ready) begin
        waiting = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (waiting) begin
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (rst_n && !calm && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= rst_n;
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t row;
    mva_pkg::res_t none;
    int sent;
    int mesh_len;
    mva_pkg::tri_t t;
    none = '0;
    vol_acc = 0; area_acc = '0; facet_cnt = 0; ovf_seen = 1'b0;
    tri_ch.valid <= 1'b0;
    tri_ch.data <= '0;

    rows.insert(rows.size(), '{make_facet(0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, 1'b1, '{0, 0, 0}});
    rows.insert(rows.size(), '{make_facet(1, 0, 0, 0, 1, 0, 0, 0, 1, 1), 1, 1'b1, '{0, 1, 0}});
    rows.insert(rows.size(), '{make_facet(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768, 1), 1, 1'b1, '{0, 0, 0}});
    rows.insert(rows.size(), '{make_facet(32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767, 1), 1, 1'b1, '{0, 0, 0}});
    // collinear points: no area
    rows.insert(rows.size(), '{make_facet(1, 2, 3, 3, 6, 9, -5, -10, -15, 1), 1, 1'b0, none});
    // negative volume truncates toward zero
    rows.insert(rows.size(), '{make_facet(-7, 0, 0, 0, 1, 0, 0, 0, 1, 1), 1, 1'b0, none});
    rows.insert(rows.size(), '{make_facet(6, 0, 0, 0, 0, 1, 0, 1, 0, 1), 1, 1'b0, none});
    rows.insert(rows.size(), '{make_facet(32767, 32767, 32767, 32767, -32768, 32767,
                                32767, 32767, -32768, 1), 1, 1'b0, none});
    rows.insert(rows.size(), '{make_facet(-32768, 32767, -32768, 32767, -32768, -32768,
                                -32768, -32768, 32767, 0), 1, 1'b0, none});
    rows.insert(rows.size(),
                '{make_facet(100, -200, 300, -32768, 5, 32767, 7, -1, 0, 1), 1, 1'b0, none});
    // a longer mesh of one repeated facet
    rows.insert(rows.size(),
                '{make_facet(1000, -3, 7, 2, 999, -5, 11, 4, -1000, 1), 100, 1'b0, none});
    // accumulators must start clean after the long mesh
    rows.insert(rows.size(), '{make_facet(1, 0, 0, 0, 1, 0, 0, 0, 1, 1), 1, 1'b1, '{0, 1, 0}});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      for (int k = 0; k < row.beats; k++) begin
        t = row.facet;
        t.last_triangle = row.facet.last_triangle && (k == row.beats - 1);
        send_facet(t, row.typed, row.want, row.beats == 1);
      end
    end

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      mesh_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int k = 0; k < mesh_len; k++) begin
        t.vertex_a_x = random_coord(); t.vertex_a_y = random_coord();
        t.vertex_a_z = random_coord(); t.vertex_b_x = random_coord();
        t.vertex_b_y = random_coord(); t.vertex_b_z = random_coord();
        t.vertex_c_x = random_coord(); t.vertex_c_y = random_coord();
        t.vertex_c_z = random_coord();
        t.last_triangle = (k == mesh_len - 1);
        if (sent >= RANDOM_BEATS - CALM_BEATS) calm = 1'b1;
        send_facet(t, 1'b0, none, !calm);
        sent++;
      end
    end
    tri_ch.valid <= 1'b0;

    while (mesh_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* filelist.f */
src/mva_pkg.sv
src/mva_if.sv
src/mva_ctrl.sv
src/mva_dp.sv
src/mesh_volume_and_area.sv
src/mva_checker.sv
dv/mesh_volume_and_area_test.sv
